// ----- rtl/bbc_pkg.sv -----
package bbc_pkg;

	localparam int unsigned BIN_W = 64;
	localparam int unsigned HI_W  = 16;
	localparam int unsigned CNT_W = 4;
	localparam int unsigned NUM_STAGES = 16;
	localparam int unsigned BITS_PER_STAGE = BIN_W / NUM_STAGES;
	localparam int unsigned BCD_W = 80;

	typedef enum logic {
		FUNC_TO_BCD = 1'b0,
		FUNC_TO_BIN = 1'b1
	} func_t;

	typedef struct packed {
		logic              func;
		logic [CNT_W-1:0]  num;
	} ctl_t;

	// One step of double dabble: add 3 to every digit at five or above, shift in one bit.
	function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
			input logic in_bit);
		logic [BCD_W-1:0] adj;
		adj = bcd;
		for (int d = 0; d < BCD_W / 4; d++) begin
			if (adj[d*4 +: 4] >= 4'd5)
				adj[d*4 +: 4] = adj[d*4 +: 4] + 4'd3;
		end
		return {adj[BCD_W-2:0], in_bit};
	endfunction

endpackage

// ----- rtl/binary_bcd_converter.sv -----
// Binary <-> packed BCD converter, one result transaction per input transaction.
// Twenty register stages: for binary to BCD the first sixteen each do four
// double-dabble shifts (64 in all) and the last four pass the digits along; for
// BCD to binary each stage folds one digit into a running sum (sum*10 + digit),
// most significant of the twenty first, with bytes at or above the count zeroed
// at entry. Counts above MAX_BCD_BYTES saturate. A transaction can enter every
// cycle while the output is not stalled; its result passes the twenty conversion
// stages, the first loaded at the accepting edge, and then the output register.
// A stalled output freezes the whole pipe and drops input ready with it.
module binary_bcd_converter #(
	parameter int MAX_BCD_BYTES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [63:0] bin_value,
	input  logic [15:0] bcd_in_high,
	input  logic [63:0] bcd_in_low,
	input  logic [3:0]  num_bytes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] bin_result,
	output logic [15:0] bcd_out_high,
	output logic [63:0] bcd_out_low
);
	import bbc_pkg::*;

	// one stage per BCD digit
	localparam int NST = BCD_W / 4;

	logic             en;
	ctl_t             ctl0;
	logic [BIN_W-1:0] sh0;
	logic [BCD_W-1:0] acc0;
	logic [BCD_W-1:0] din;
	logic [BCD_W-1:0] bcd_src;
	logic [3:0]       n_sat;

	logic             v   [NST+1];
	ctl_t             c   [NST+1];
	logic [BIN_W-1:0] s   [NST+1];
	logic [BCD_W-1:0] a   [NST+1];

	logic [BIN_W-1:0] bin_res;
	logic [BCD_W-1:0] bcd_res;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_comb begin
		n_sat = (num_bytes > 4'(MAX_BCD_BYTES)) ? 4'(MAX_BCD_BYTES) : num_bytes;
		if (n_sat > 4'd10)
			n_sat = 4'd10;
		bcd_src = {bcd_in_high, bcd_in_low};
		din = '0;
		for (int p = 0; p < BCD_W / 8; p++) begin
			if (p < int'(n_sat))
				din[p*8 +: 8] = bcd_src[p*8 +: 8];
		end
		ctl0.func = func;
		ctl0.num  = n_sat;
		if (func == FUNC_TO_BCD) begin
			sh0  = bin_value;
			acc0 = '0;
		end else begin
			sh0  = '0;
			acc0 = din;
		end
	end

	assign v[0] = in_valid;
	assign c[0] = ctl0;
	assign s[0] = sh0;
	assign a[0] = acc0;

	// The first NUM_STAGES stages carry the 64 dabble shifts; to binary uses all
	// stages for one digit each.
	for (genvar g = 0; g < NST; g++) begin : g_st
		bbc_stage u_st (
			.clk(clk), .arst_n(arst_n), .en(en),
			.shift_en((g < NUM_STAGES) ? 1'b1 : 1'b0),
			.valid_in(v[g]), .ctl_in(c[g]), .shreg_in(s[g]), .acc_in(a[g]),
			.valid_out(v[g+1]), .ctl_out(c[g+1]), .shreg_out(s[g+1]), .acc_out(a[g+1])
		);
	end

	bbc_mask u_mask (
		.ctl(c[NST]), .shreg(s[NST]), .acc(a[NST]),
		.bin_res(bin_res), .bcd_res(bcd_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= v[NST];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bin_result   <= bin_res;
			bcd_out_high <= bcd_res[BCD_W-1 -: HI_W];
			bcd_out_low  <= bcd_res[BIN_W-1:0];
		end
	end

endmodule

// ----- rtl/bbc_stage.sv -----
module bbc_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    shift_en,
	input  logic                    valid_in,
	input  bbc_pkg::ctl_t           ctl_in,
	input  logic [bbc_pkg::BIN_W-1:0] shreg_in,
	input  logic [bbc_pkg::BCD_W-1:0] acc_in,
	output logic                    valid_out,
	output bbc_pkg::ctl_t           ctl_out,
	output logic [bbc_pkg::BIN_W-1:0] shreg_out,
	output logic [bbc_pkg::BCD_W-1:0] acc_out
);
	import bbc_pkg::*;

	logic [BIN_W-1:0] sh_nxt;
	logic [BCD_W-1:0] acc_nxt;

	// To BCD: shreg holds remaining binary bits, acc the digits.
	// To binary: shreg holds the running sum, acc the remaining digits (top first).
	// Without shift_en a to-BCD transaction passes through unchanged.
	always_comb begin
		sh_nxt  = shreg_in;
		acc_nxt = acc_in;
		for (int b = 0; b < BITS_PER_STAGE; b++) begin
			if (shift_en && ctl_in.func == FUNC_TO_BCD) begin
				acc_nxt = dabble_step(acc_nxt, sh_nxt[BIN_W-1]);
				sh_nxt  = {sh_nxt[BIN_W-2:0], 1'b0};
			end
		end
		if (ctl_in.func == FUNC_TO_BIN) begin
			// Absorb one digit per stage: sum*10 + top nibble.
			sh_nxt  = (shreg_in << 3) + (shreg_in << 1)
				+ {{(BIN_W-4){1'b0}}, acc_in[BCD_W-1 -: 4]};
			acc_nxt = {acc_in[BCD_W-5:0], 4'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_out   <= ctl_in;
			shreg_out <= sh_nxt;
			acc_out   <= acc_nxt;
		end
	end

endmodule

// ----- rtl/bbc_mask.sv -----
module bbc_mask (
	input  bbc_pkg::ctl_t             ctl,
	input  logic [bbc_pkg::BIN_W-1:0] shreg,
	input  logic [bbc_pkg::BCD_W-1:0] acc,
	output logic [bbc_pkg::BIN_W-1:0] bin_res,
	output logic [bbc_pkg::BCD_W-1:0] bcd_res
);
	import bbc_pkg::*;

	always_comb begin
		bcd_res = '0;
		bin_res = '0;
		if (ctl.func == FUNC_TO_BCD) begin
			for (int p = 0; p < BCD_W / 8; p++) begin
				if (p < int'(ctl.num))
					bcd_res[p*8 +: 8] = acc[p*8 +: 8];
			end
		end else begin
			bin_res = shreg;
		end
	end

endmodule

// ----- rtl/bbc_checker.sv -----
module bbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] bin_result,
	input logic [15:0] bcd_out_high,
	input logic [63:0] bcd_out_low
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_result))
		else $error("output dropped while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bin_result != 64'd0 |-> bcd_out_high == 16'd0 && bcd_out_low == 64'd0)
		else $error("both result kinds set");
endmodule

bind binary_bcd_converter bbc_checker u_bbc_checker (.*);
